FILE: rtl/assert_macros.svh
// Assertion macros shared by the word table search RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Check on every rising edge, off while reset is held.
`define ASSERT_R(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("assertion failed");
// Check on every rising edge, reset included.
`define ASSERT_NR(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("assertion failed");
`else
`define ASSERT_R(label, clk, rst_n, prop)
`define ASSERT_NR(label, clk, prop)
`endif

`endif

FILE: rtl/wts_pkg.sv
// Package for the word table search: widths, codes, result type, word normalize.
// No dependencies; used by the interfaces and all modules.
`timescale 1ns / 1ps
`default_nettype none

package wts_pkg;

    localparam int unsigned WORD_HEAD_W     = 64;
    localparam int unsigned WORD_TAIL_W     = 40;
    localparam int unsigned FULL_BYTES      = 13;
    localparam int unsigned FULL_W          = WORD_HEAD_W + WORD_TAIL_W;
    localparam int unsigned PROBE_W         = 13;
    localparam int unsigned DEF_TABLE_DEPTH = 4096;
    localparam int unsigned DEF_WORD_BYTES  = 13;

    typedef enum logic {
        OP_APPEND = 1'b0,
        OP_SEARCH = 1'b1
    } t_op;

    typedef enum logic {
        MODE_SCAN   = 1'b0,
        MODE_BISECT = 1'b1
    } t_mode;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_BIS_RD,
        ST_BIS_CMP,
        ST_END_LO,
        ST_END_HI,
        ST_END_CMP,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic               found;
        logic [PROBE_W-1:0] probe_count;
    } t_result;

    // Zero every byte after the first zero byte and every byte at or past nbytes.
    function automatic logic [FULL_W-1:0] normalize_word(
        input logic [WORD_HEAD_W-1:0] head,
        input logic [WORD_TAIL_W-1:0] tail,
        input int                     nbytes
    );
        logic [FULL_W-1:0] w;
        logic              ended;
        logic [7:0]        b;
        w     = {head, tail};
        ended = 1'b0;
        for (int i = 0; i < int'(FULL_BYTES); i++) begin
            b = w[FULL_W-1-8*i -: 8];
            if (i >= nbytes) begin
                ended = 1'b1;
            end
            if (ended) begin
                w[FULL_W-1-8*i -: 8] = 8'h00;
            end else if (b == 8'h00) begin
                ended = 1'b1;
            end
        end
        return w;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/wts_in_if.sv
// Request channel of the word table search: valid/ready plus the word beat.
// Depends on wts_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface wts_in_if;
    logic                             valid;
    logic                             ready;
    logic                             operation;
    logic [wts_pkg::WORD_HEAD_W-1:0]  word_head;
    logic [wts_pkg::WORD_TAIL_W-1:0]  word_tail;

    modport source (output valid, operation, word_head, word_tail, input ready);
    modport sink   (input valid, operation, word_head, word_tail, output ready);
endinterface

`default_nettype wire

FILE: rtl/wts_out_if.sv
// Result channel of the word table search: valid/ready plus found and probe count.
// Depends on wts_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface wts_out_if;
    logic                         valid;
    logic                         ready;
    logic                         found;
    logic [wts_pkg::PROBE_W-1:0]  probe_count;

    modport source (output valid, found, probe_count, input ready);
    modport sink   (input valid, found, probe_count, output ready);
endinterface

`default_nettype wire

FILE: rtl/wts_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on wts_pkg only for default sizes.
`timescale 1ns / 1ps
`default_nettype none

module wts_ram #(
    parameter int unsigned WIDTH = 8 * wts_pkg::DEF_WORD_BYTES,
    parameter int unsigned DEPTH = wts_pkg::DEF_TABLE_DEPTH
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

`default_nettype wire

FILE: rtl/wts_engine.sv
// Search engine: word store RAM, entry count, scan and bisection sequencer.
// Depends on wts_pkg, wts_in_if, wts_ram and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module wts_engine #(
    parameter int unsigned TABLE_DEPTH = wts_pkg::DEF_TABLE_DEPTH,
    parameter int unsigned WORD_BYTES  = wts_pkg::DEF_WORD_BYTES
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_mode,
    wts_in_if.sink           i_req,
    output logic             o_res_valid,
    output wts_pkg::t_result o_res,
    input  logic             i_res_ready
);
    import wts_pkg::*;

    localparam int unsigned AW  = $clog2(TABLE_DEPTH);
    localparam int unsigned CW  = $clog2(TABLE_DEPTH + 1);
    localparam int unsigned PCW = $clog2(TABLE_DEPTH + 2);
    localparam int unsigned WW  = 8 * WORD_BYTES;
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

    t_state           r_state, n_state;
    logic [CW-1:0]    r_count, n_count;
    logic [WW-1:0]    r_key, n_key;
    logic [AW-1:0]    r_lo, n_lo, r_hi, n_hi, r_mid, n_mid;
    logic [CW-1:0]    r_issue, n_issue;
    logic             r_dv, n_dv;
    logic [PCW-1:0]   r_probe, n_probe;
    logic             r_found, n_found;

    logic [FULL_W-1:0] w_in_word;
    logic              w_ram_we;
    logic [AW-1:0]     w_raddr;
    logic [WW-1:0]     w_rdata;
    logic              w_eq, w_gt;
    logic [AW:0]       w_sum;
    logic [AW-1:0]     w_centre;
    logic              w_adjacent;

    assign w_in_word  = normalize_word(i_req.word_head, i_req.word_tail, int'(WORD_BYTES));
    assign w_eq       = (w_rdata == r_key);
    assign w_gt       = (w_rdata > r_key);
    assign w_sum      = {1'b0, r_lo} + {1'b0, r_hi};
    assign w_centre   = w_sum[AW:1];
    assign w_adjacent = ((r_hi - r_lo) == AW'(1));

    wts_ram #(
        .WIDTH (WW),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (w_in_word[FULL_W-1 -: WW]),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_key       = r_key;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_mid       = r_mid;
        n_issue     = r_issue;
        n_dv        = 1'b0;
        n_probe     = r_probe;
        n_found     = r_found;
        w_ram_we    = 1'b0;
        w_raddr     = '0;
        i_req.ready = 1'b0;
        o_res_valid = 1'b0;
        case (r_state)
            ST_IDLE: begin
                // hold off new beats while reset is applied
                i_req.ready = i_rst_n;
                if (i_rst_n && i_req.valid) begin
                    if (i_req.operation == OP_APPEND) begin
                        // drop the word when the table is full
                        if (r_count < DEPTH_C) begin
                            w_ram_we = 1'b1;
                            n_count  = r_count + 1'b1;
                        end
                    end else begin
                        n_key   = w_in_word[FULL_W-1 -: WW];
                        n_probe = PCW'(1);
                        n_found = 1'b0;
                        if (r_count == '0) begin
                            n_state = ST_DONE;
                        end else if (i_mode == MODE_SCAN) begin
                            n_issue = '0;
                            n_state = ST_SCAN;
                        end else if (r_count == CW'(1)) begin
                            n_lo    = '0;
                            n_hi    = '0;
                            n_state = ST_END_LO;
                        end else begin
                            n_lo    = '0;
                            n_hi    = AW'(r_count - 1'b1);
                            n_state = ST_BIS_RD;
                        end
                    end
                end
            end
            ST_SCAN: begin
                // issue one read a cycle, compare the one returned
                w_raddr = r_issue[AW-1:0];
                if (r_issue < r_count) begin
                    n_issue = r_issue + 1'b1;
                    n_dv    = 1'b1;
                end
                if (r_dv) begin
                    if (w_eq) begin
                        n_found = 1'b1;
                        n_state = ST_DONE;
                    end else begin
                        n_probe = r_probe + 1'b1;
                        if (r_issue == r_count) begin
                            n_state = ST_DONE;
                        end
                    end
                end
            end
            ST_BIS_RD: begin
                if (w_adjacent) begin
                    n_state = ST_END_LO;
                end else begin
                    w_raddr = w_centre;
                    n_mid   = w_centre;
                    n_state = ST_BIS_CMP;
                end
            end
            ST_BIS_CMP: begin
                if (w_eq) begin
                    n_found = 1'b1;
                    n_state = ST_DONE;
                end else begin
                    if (w_gt) begin
                        n_hi = r_mid;
                    end else begin
                        n_lo = r_mid;
                    end
                    n_probe = r_probe + 1'b1;
                    n_state = ST_BIS_RD;
                end
            end
            ST_END_LO: begin
                w_raddr = r_lo;
                n_state = ST_END_HI;
            end
            ST_END_HI: begin
                w_raddr = r_hi;
                n_found = w_eq;
                n_state = ST_END_CMP;
            end
            ST_END_CMP: begin
                n_found = r_found | w_eq;
                n_state = ST_DONE;
            end
            ST_DONE: begin
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_dv    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_dv    <= n_dv;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key   <= n_key;
        r_lo    <= n_lo;
        r_hi    <= n_hi;
        r_mid   <= n_mid;
        r_issue <= n_issue;
        r_probe <= n_probe;
        r_found <= n_found;
    end

    assign o_res.found       = r_found;
    assign o_res.probe_count = PROBE_W'(r_probe);

    `ASSERT_R(a_scan_issue_bound, i_clk, i_rst_n, (r_state == ST_SCAN) |-> (r_issue <= r_count))
    `ASSERT_R(a_bisect_mid_inside, i_clk, i_rst_n, (r_state == ST_BIS_CMP) |-> ((r_lo < r_mid) && (r_mid < r_hi)))
    `ASSERT_R(a_append_grows, i_clk, i_rst_n, (i_req.valid && i_req.ready && (i_req.operation == OP_APPEND) && (r_count < DEPTH_C)) |=> (r_count == $past(r_count) + 1'b1))
    `ASSERT_R(a_probe_bound, i_clk, i_rst_n, o_res_valid |-> ((r_probe != '0) && (r_probe <= PCW'(r_count) + 1'b1)))
endmodule

`default_nettype wire

FILE: rtl/word_table_search.sv
// Top level of the word table search: config register, result register, engine.
// Depends on wts_pkg, wts_in_if, wts_out_if, wts_engine and assert_macros.svh.
//
//   channel   dir  handshake           beat contents
//   i_req     in   valid/ready         operation, word_head, word_tail
//   o_rsp     out  valid/ready         found, probe_count
//   cfg       in   i_cfg_we (no wait)  i_cfg_wdata = search_mode
//
// A scan search over n entries issues one RAM read per cycle. A bisection
// search halves the range at each step: every step waits on the registered
// read data of the single read port of the word store.
// Reset is synchronous; it empties the table at once, the store is not swept.
// A result waits in the output register; the engine takes the next beat as
// soon as it has handed its result over.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module word_table_search #(
    parameter int unsigned TABLE_DEPTH = wts_pkg::DEF_TABLE_DEPTH,
    parameter int unsigned WORD_BYTES  = wts_pkg::DEF_WORD_BYTES
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    wts_in_if.sink     i_req,
    wts_out_if.source  o_rsp,
    input  logic       i_cfg_we,
    input  logic       i_cfg_wdata
);
    import wts_pkg::*;

    // search_mode register
    logic    r_mode;
    // output register between engine and result channel
    logic    r_out_valid;
    t_result r_out;

    logic    w_res_valid;
    logic    w_res_ready;
    t_result w_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_SCAN;
        end else if (i_cfg_we) begin
            r_mode <= i_cfg_wdata;
        end
    end

    wts_engine #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .WORD_BYTES  (WORD_BYTES)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_mode      (r_mode),
        .i_req       (i_req),
        .o_res_valid (w_res_valid),
        .o_res       (w_res),
        .i_res_ready (w_res_ready)
    );

    // take a new result whenever the register is empty or drains this cycle
    assign w_res_ready = !r_out_valid || o_rsp.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_valid && w_res_ready) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // hold the payload until the next handoff
    always_ff @(posedge i_clk) begin
        if (w_res_valid && w_res_ready) begin
            r_out <= w_res;
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.found       = r_out.found;
    assign o_rsp.probe_count = r_out.probe_count;

    `ASSERT_NR(a_reset_empties_output, i_clk, !i_rst_n |=> !o_rsp.valid)
    `ASSERT_R(a_accept_only_when_no_result, i_clk, i_rst_n, i_req.ready |-> !w_res_valid)
    `ASSERT_R(a_handoff_loads, i_clk, i_rst_n, (w_res_valid && w_res_ready) |=> (o_rsp.valid && (o_rsp.probe_count == $past(w_res.probe_count))))
    `ASSERT_R(a_rise_after_handoff, i_clk, i_rst_n, $rose(o_rsp.valid) |-> $past(w_res_valid))
endmodule

`default_nettype wire
